// ===== rtl/b64d_pkg.sv =====
// shared types, constants and alphabet map for the base64 decoder
`default_nettype none
package b64d_pkg;

  localparam logic [7:0] PadChar = 8'h3D;
  localparam logic [1:0] PosLast = 2'd3;
  localparam logic [1:0] PosFirstLegalPad = 2'd2;

  localparam int QDepth = 4;
  localparam int QAw = $clog2(QDepth);
  localparam int QCw = $clog2(QDepth + 1);

  // byte counts carried with a decoded group
  localparam logic [1:0] CntOne = 2'd1;
  localparam logic [1:0] CntTwo = 2'd2;
  localparam logic [1:0] CntThree = 2'd3;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sx_t;

  // one queue entry: a decoded group or an error marker
  typedef struct packed {
    logic [23:0] triple;
    logic [1:0]  count;
    logic        last;
    logic        err;
  } grp_word_t;

  typedef struct packed {
    logic           full;
    logic           empty;
    logic [QCw-1:0] count;
  } q_stat_t;

  function automatic sx_t sextet_of(logic [7:0] c);
    sx_t r;
    r.ok  = 1'b1;
    r.val = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.val = 6'(c - 8'h47);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.val = 6'(c + 8'h04);
    end else if (c == 8'h2B) begin
      r.val = 6'd62;
    end else if (c == 8'h2F) begin
      r.val = 6'd63;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/b64d_front.sv =====
// front end: character classification, validation and group assembly
`default_nettype none
module b64d_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_accept,
  input  wire logic [7:0]            char_code,
  input  wire logic                  final_char,
  output logic                       push,
  output b64d_pkg::grp_word_t        push_word
);

  logic [1:0]  pos_r, pos_nxt;
  logic [17:0] store_r, store_nxt;
  logic        tpad_r, tpad_nxt;
  logic        err_r, err_nxt;

  b64d_pkg::sx_t sx;
  logic          pad;
  logic [5:0]    v;
  logic          err_now;
  logic          at_end;

  always_comb begin
    sx      = b64d_pkg::sextet_of(char_code);
    pad     = (char_code == b64d_pkg::PadChar);
    v       = (pad || !sx.ok) ? 6'd0 : sx.val;
    at_end  = (pos_r == b64d_pkg::PosLast);
    err_now = err_r;
    if (!err_r) begin
      if (pad && pos_r < b64d_pkg::PosFirstLegalPad) err_now = 1'b1;
      if (!pad && !sx.ok) err_now = 1'b1;
      if (at_end && !pad && tpad_r) err_now = 1'b1;
      if (at_end && !final_char && (pad || tpad_r)) err_now = 1'b1;
      if (final_char && !at_end) err_now = 1'b1;
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    store_nxt = store_r;
    tpad_nxt  = tpad_r;
    err_nxt   = err_r;
    push      = 1'b0;
    push_word.triple = {store_r, v};
    push_word.last   = final_char;
    push_word.err    = err_now;
    if (tpad_r) begin
      push_word.count = b64d_pkg::CntOne;
    end else if (pad) begin
      push_word.count = b64d_pkg::CntTwo;
    end else begin
      push_word.count = b64d_pkg::CntThree;
    end
    if (in_accept) begin
      err_nxt = err_now;
      if (!err_r && pos_r == b64d_pkg::PosFirstLegalPad && pad) tpad_nxt = 1'b1;
      if (!err_now) begin
        if (!at_end) begin
          store_nxt = {store_r[11:0], v};
          pos_nxt   = pos_r + 2'd1;
        end else begin
          push      = 1'b1;
          store_nxt = '0;
          pos_nxt   = '0;
          tpad_nxt  = 1'b0;
        end
      end else if (final_char) begin
        push = 1'b1;
      end
      if (final_char) begin
        pos_nxt   = '0;
        store_nxt = '0;
        tpad_nxt  = 1'b0;
        err_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      store_r <= '0;
      tpad_r  <= 1'b0;
      err_r   <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      store_r <= store_nxt;
      tpad_r  <= tpad_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/b64d_fifo.sv =====
// show-ahead queue of decoded groups between front and back end
`default_nettype none
module b64d_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire b64d_pkg::grp_word_t  push_word,
  input  wire logic                 pop,
  output b64d_pkg::grp_word_t       head_word,
  output b64d_pkg::q_stat_t         stat
);

  b64d_pkg::grp_word_t slot_r [b64d_pkg::QDepth];
  logic [b64d_pkg::QAw-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [b64d_pkg::QAw-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [b64d_pkg::QCw-1:0] cnt_r, cnt_nxt;

  always_comb begin
    stat.count = cnt_r;
    stat.full  = (cnt_r == b64d_pkg::QCw'(b64d_pkg::QDepth));
    stat.empty = (cnt_r == '0);
    head_word  = slot_r[rd_ptr_r];
    wr_ptr_nxt = push ? wr_ptr_r + b64d_pkg::QAw'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + b64d_pkg::QAw'(1) : rd_ptr_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + b64d_pkg::QCw'(1);
      2'b01:   cnt_nxt = cnt_r - b64d_pkg::QCw'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/b64d_back.sv =====
// back end: expands queued groups into output bytes through an output register
`default_nettype none
module b64d_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire b64d_pkg::grp_word_t  head_word,
  input  wire logic                 head_valid,
  output logic                      pop,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [7:0]                out_tdata,
  output logic                      out_tlast,
  output logic                      out_tuser
);

  logic [1:0] idx_r, idx_nxt;
  logic       vld_r, vld_nxt;
  logic [7:0] data_r, data_nxt;
  logic       last_r, last_nxt;
  logic       bad_r, bad_nxt;

  logic       load;
  logic       final_byte;
  logic [7:0] byte_sel;

  always_comb begin
    case (idx_r)
      2'd0:    byte_sel = head_word.triple[23:16];
      2'd1:    byte_sel = head_word.triple[15:8];
      default: byte_sel = head_word.triple[7:0];
    endcase
    final_byte = head_word.err || (idx_r + 2'd1 == head_word.count);
    load       = head_valid && (!vld_r || out_tready);
    pop        = load && final_byte;

    idx_nxt  = idx_r;
    vld_nxt  = vld_r && !out_tready;
    data_nxt = data_r;
    last_nxt = last_r;
    bad_nxt  = bad_r;
    if (load) begin
      vld_nxt  = 1'b1;
      idx_nxt  = final_byte ? 2'd0 : idx_r + 2'd1;
      data_nxt = head_word.err ? 8'd0 : byte_sel;
      last_nxt = head_word.err || (head_word.last && final_byte);
      bad_nxt  = head_word.err;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;
  assign out_tuser  = bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    last_r <= last_nxt;
    bad_r  <= bad_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/base64_decoder_validating_unit.sv =====
// top level of the validating base64 decoder
//
//   channel | dir | tdata          | tlast         | tuser
//   in_     | in  | char_code[7:0] | final_char    | -
//   out_    | out | data_byte[7:0] | end_of_output | bad_input
//
// one character accepted per cycle while the group queue has room
// a complete group of four expands into one to three output words, one per cycle while the sink is ready
// the four-entry group queue absorbs output stalls; input stalls only when it fills
// reset is synchronous, active low, and empties the queue and output register
`default_nettype none
module base64_decoder_validating_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // char_code
  input  wire logic       in_tlast,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // data_byte
  output logic            out_tlast,
  output logic            out_tuser   // bad_input
);

  b64d_pkg::grp_word_t push_word;
  b64d_pkg::grp_word_t head_word;
  b64d_pkg::q_stat_t   q_stat;
  logic                push;
  logic                pop;
  logic                in_accept;

  assign in_tready = !q_stat.full;
  assign in_accept = in_tvalid && in_tready;

  b64d_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_accept  (in_accept),
    .char_code  (in_tdata),
    .final_char (in_tlast),
    .push       (push),
    .push_word  (push_word)
  );

  b64d_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .head_word (head_word),
    .stat      (q_stat)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_word  (head_word),
    .head_valid (!q_stat.empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTHESIS
  a_bad_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && out_tdata == 8'd0)
    else $error("error word without end marker or with data");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= b64d_pkg::QCw'(b64d_pkg::QDepth))
    else $error("group queue over depth");

  a_queue_count: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> q_stat.count == $past(q_stat.count) + b64d_pkg::QCw'(1))
    else $error("group queue count lost a push");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty group queue");
`endif

endmodule
`default_nettype wire

// ===== test/base64_decoder_validating_unit_tb.sv =====
// self-checking testbench for the validating base64 decoder: stream drivers, byte predictor
`default_nettype none
module base64_decoder_validating_unit_tb;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       bad;
  } dec_byte_t;

  class b64_byte_scoreboard;
    logic [1:0]  pos;
    logic [17:0] store;
    logic        third_pad;
    logic        err_latched;
    dec_byte_t   expected_bytes[$];
    int          mismatches;
    int          words_checked;
    int          strings_done;
    int          strings_bad;

    function new();
      pos = 2'd0;
      store = 18'd0;
      third_pad = 1'b0;
      err_latched = 1'b0;
      mismatches = 0;
      words_checked = 0;
      strings_done = 0;
      strings_bad = 0;
    endfunction

    // returns 1 if the character was taken while no error was latched
    function bit note_char(logic [7:0] c, logic last);
      logic        pad;
      logic        ok;
      logic [5:0]  v;
      logic [23:0] triple;
      int          count;
      bit          live;
      dec_byte_t   r;
      live = !err_latched;
      pad = (c == b64d_pkg::PadChar);
      ok = 1'b1;
      v = 6'd0;
      if (c >= "A" && c <= "Z") v = 6'(c - "A");
      else if (c >= "a" && c <= "z") v = 6'(c - "a" + 26);
      else if (c >= "0" && c <= "9") v = 6'(c - "0" + 52);
      else if (c == "+") v = 6'd62;
      else if (c == "/") v = 6'd63;
      else ok = 1'b0;
      if (!err_latched) begin
        if (pad) begin
          if (pos < b64d_pkg::PosFirstLegalPad) err_latched = 1'b1;
          v = 6'd0;
        end else if (!ok) begin
          err_latched = 1'b1;
          v = 6'd0;
        end
        if (pos == b64d_pkg::PosLast && !pad && third_pad) err_latched = 1'b1;
        if (pos == b64d_pkg::PosFirstLegalPad && pad) third_pad = 1'b1;
        if (pos == b64d_pkg::PosLast && !last && (pad || third_pad)) err_latched = 1'b1;
        if (last && pos != b64d_pkg::PosLast) err_latched = 1'b1;
        if (!err_latched) begin
          if (pos != b64d_pkg::PosLast) begin
            store = {store[11:0], v};
            pos = pos + 2'd1;
          end else begin
            triple = {store, v};
            count = third_pad ? 1 : (pad ? 2 : 3);
            for (int k = 0; k < count; k++) begin
              r.data = triple[23 - 8 * k -: 8];
              r.last = last && (k == count - 1);
              r.bad = 1'b0;
              expected_bytes = {expected_bytes, r};
            end
            pos = 2'd0;
            store = 18'd0;
            third_pad = 1'b0;
          end
        end
      end
      if (err_latched && last) begin
        r.data = 8'd0;
        r.last = 1'b1;
        r.bad = 1'b1;
        expected_bytes = {expected_bytes, r};
        strings_bad++;
      end
      if (last) begin
        pos = 2'd0;
        store = 18'd0;
        third_pad = 1'b0;
        err_latched = 1'b0;
        strings_done++;
      end
      return live;
    endfunction

    function void check_byte(logic [7:0] data, logic last, logic bad);
      dec_byte_t want;
      dec_byte_t got;
      got = '{data: data, last: last, bad: bad};
      words_checked++;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: data=%02h last=%0b bad=%0b", data, last, bad);
        return;
      end
      want = expected_bytes.pop_front();
      if (got.data !== want.data || got.last !== want.last || got.bad !== want.bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected data=%02h last=%0b bad=%0b, got data=%02h last=%0b bad=%0b",
                   want.data, want.last, want.bad, got.data, got.last, got.bad);
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  typedef enum logic [1:0] {RxOpen, RxRandom, RxSlow} rx_mode_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'd0;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       out_tuser;

  b64_byte_scoreboard sb;
  logic [7:0] msg[$];
  int         burst_left = 0;
  int         live_chars = 0;
  int         all_chars = 0;
  rx_mode_t   rx_mode = RxOpen;
  int         rx_left = 0;

  base64_decoder_validating_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      rx_left <= $urandom_range(8, 60);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RxOpen:   out_tready <= 1'b1;
      RxRandom: out_tready <= 1'($urandom_range(0, 1));
      default:  out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_byte(out_tdata, out_tlast, out_tuser);
  end

  function automatic logic [7:0] symbol_char(logic [5:0] s);
    if (s < 26) return 8'("A" + s);
    if (s < 52) return 8'("a" + s - 26);
    if (s < 62) return 8'("0" + s - 52);
    return (s == 6'd62) ? 8'("+") : 8'("/");
  endfunction

  task automatic send_char(logic [7:0] c, logic last);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 10);
      gap = $urandom_range(0, 5);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    all_chars++;
    if (sb.note_char(c, last)) live_chars++;
  endtask

  task automatic send_msg();
    foreach (msg[i]) send_char(msg[i], i == msg.size() - 1);
    msg.delete();
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) msg = {msg, s[i]};
    send_msg();
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // appends one group of four symbols carrying nbytes bytes
  task automatic add_group(int nbytes);
    logic [23:0] triple;
    triple = 24'($urandom());
    if ($urandom_range(0, 5) == 0) triple = ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h0;
    msg = {msg, symbol_char(triple[23:18])};
    msg = {msg, symbol_char(triple[17:12])};
    msg = {msg, (nbytes > 1 ? symbol_char(triple[11:6]) : b64d_pkg::PadChar)};
    msg = {msg, (nbytes > 2 ? symbol_char(triple[5:0]) : b64d_pkg::PadChar)};
  endtask

  task automatic add_wellformed();
    int groups;
    groups = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 3);
    for (int g = 0; g < groups - 1; g++) add_group(3);
    add_group($urandom_range(1, 3));
  endtask

  task automatic add_broken();
    int spot;
    case ($urandom_range(0, 3))
      0: begin
        add_wellformed();
        spot = $urandom_range(0, msg.size() - 1);
        msg[spot] = 8'($urandom_range(0, 255));
      end
      1: begin
        add_wellformed();
        spot = $urandom_range(0, msg.size() - 1);
        msg[spot] = b64d_pkg::PadChar;
      end
      2: begin
        add_wellformed();
        if ($urandom_range(0, 1) != 0) void'(msg.pop_back());
        else msg = {msg, symbol_char(6'($urandom()))};
      end
      default: begin
        add_group($urandom_range(1, 2));
        add_wellformed();
      end
    endcase
  endtask

  task automatic add_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      case ($urandom_range(0, 2))
        0: msg = {msg, 8'($urandom_range(0, 255))};
        1: msg = {msg, b64d_pkg::PadChar};
        default: msg = {msg, symbol_char(6'($urandom()))};
      endcase
    end
  endtask

  initial begin
    #400000;
    $display("timeout: decoder stopped making progress");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    bit drained_mid;
    int failures;
    sb = new();
    drained_mid = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed strings
    send_text("+/z0AA==");
    send_text("/9A=");
    send_text("A");
    send_text("=A");
    send_text("AB=C");
    send_text("AB==A");
    msg = {msg, 8'h00};
    msg = {msg, 8'hFF};
    send_msg();
    wait_drain();

    while (all_chars < 280) begin
      case ($urandom_range(0, 9))
        7, 8:    add_broken();
        9:       add_noise();
        default: add_wellformed();
      endcase
      send_msg();
      if (!drained_mid && all_chars > 140) begin
        drained_mid = 1;
        wait_drain();
      end
    end

    wait_drain();
    repeat (20) @(posedge clk);
    failures = sb.mismatches + sb.pending();
    if (sb.pending() != 0) $display("%0d expected words never arrived", sb.pending());
    $display("sent %0d characters (%0d before any error) in %0d strings, %0d of them invalid",
             all_chars, live_chars, sb.strings_done, sb.strings_bad);
    $display("checked %0d output words under random source gaps and sink stalls",
             sb.words_checked);
    if (failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
